[hdl/tprc_pkg.sv]
// Shared types, constants and functions for the tile request priority compare block.
// Used by every module in hdl/; depends on nothing.
`default_nettype none
package tprc_pkg;

  localparam int REGION_SLOTS = 2;
  localparam int COORD_W      = 31;
  localparam int LEVEL_W      = 5;
  localparam int REG_W        = 64;
  localparam int CFG_IDX_W    = 3;
  // Signed working width: holds x+w-1 of a tile, left+width of a region, and -1.
  localparam int SPAN_W       = 35;
  localparam int DIST_W       = 32;
  localparam int SQ_W         = 2 * DIST_W;

  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RES_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE   = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0]                    focus_x;
    logic [COORD_W-1:0]                    focus_y;
    logic                                  low_res_first;
    logic [1:0]                            region_count;
    logic [REGION_SLOTS-1:0][REG_W-1:0]    region_origin;
    logic [REGION_SLOTS-1:0][REG_W-1:0]    region_extent;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [LEVEL_W-1:0] level;
  } req_t;

  typedef struct packed {
    req_t a;
    req_t b;
  } req_pair_t;

  typedef struct packed {
    logic               hit;
    logic               hold;
    logic [DIST_W-1:0]  dx;
    logic [DIST_W-1:0]  dy;
    logic [LEVEL_W-1:0] level;
  } geom_t;

  typedef struct packed {
    geom_t a;
    geom_t b;
  } geom_pair_t;

  typedef struct packed {
    logic               hit;
    logic               hold;
    logic [SQ_W-1:0]    sqx;
    logic [SQ_W-1:0]    sqy;
    logic [LEVEL_W-1:0] level;
  } sq_t;

  typedef struct packed {
    sq_t a;
    sq_t b;
  } sq_pair_t;

  localparam logic signed [SPAN_W-1:0] SPAN_ONE = SPAN_W'(1);

  // Region overlap, focus containment and per-axis gap to the nearest pixel.
  function automatic geom_t req_geom(req_t r, cfg_t c);
    logic signed [SPAN_W-1:0] x1, y1, x2, y2, fx, fy;
    logic signed [SPAN_W-1:0] rl, rt, rr, rb, gx, gy;
    geom_t g;
    x1 = $signed({4'b0, r.x});
    y1 = $signed({4'b0, r.y});
    x2 = x1 + $signed({4'b0, r.w}) - SPAN_ONE;
    y2 = y1 + $signed({4'b0, r.h}) - SPAN_ONE;
    fx = $signed({4'b0, c.focus_x});
    fy = $signed({4'b0, c.focus_y});
    g.hit = 1'b0;
    for (int i = 0; i < REGION_SLOTS; i++) begin
      rl = $signed({3'b0, c.region_origin[i][63:32]});
      rt = $signed({3'b0, c.region_origin[i][31:0]});
      rr = rl + $signed({3'b0, c.region_extent[i][63:32]});
      rb = rt + $signed({3'b0, c.region_extent[i][31:0]});
      if (({30'b0, c.region_count} > 32'(i)) &&
          !(rl > x2 || rt > y2 || rr < x1 || rb < y1)) begin
        g.hit = 1'b1;
      end
    end
    g.hold = (fx >= x1) && (fy >= y1) && (fx <= x2) && (fy <= y2);
    // Clamp the focus to the span; the low end wins on an inverted span.
    if (fx < x1) begin
      gx = x1 - fx;
    end else if (fx > x2) begin
      gx = fx - x2;
    end else begin
      gx = '0;
    end
    if (fy < y1) begin
      gy = y1 - fy;
    end else if (fy > y2) begin
      gy = fy - y2;
    end else begin
      gy = '0;
    end
    g.dx    = gx[DIST_W-1:0];
    g.dy    = gy[DIST_W-1:0];
    g.level = r.level;
    return g;
  endfunction

  function automatic logic level_after(logic [LEVEL_W-1:0] la, logic [LEVEL_W-1:0] lb,
                                       logic low_res_first);
    logic res;
    if (la == lb) begin
      res = 1'b0;
    end else if (low_res_first) begin
      res = (la < lb);
    end else begin
      res = (la > lb);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/tprc_geom.sv]
// Geometry stage: region overlap, focus containment and axis gaps for both requests.
// Depends on tprc_pkg.
`default_nettype none
module tprc_geom (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tprc_pkg::cfg_t        cfg,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire tprc_pkg::req_pair_t   up_req,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output tprc_pkg::geom_pair_t       dn_geom
);

  logic                  valid_r;
  tprc_pkg::geom_pair_t  geom_r;
  tprc_pkg::geom_pair_t  geom_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    geom_nxt.a = tprc_pkg::req_geom(up_req.a, cfg);
    geom_nxt.b = tprc_pkg::req_geom(up_req.b, cfg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      geom_r <= geom_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_geom  = geom_r;

endmodule
`default_nettype wire

[hdl/tprc_square.sv]
// Square stage: squares the per-axis gaps of both requests, one product per axis.
// Depends on tprc_pkg.
`default_nettype none
module tprc_square (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire tprc_pkg::geom_pair_t  up_geom,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output tprc_pkg::sq_pair_t         dn_sq
);

  logic                valid_r;
  tprc_pkg::sq_pair_t  sq_r;
  tprc_pkg::sq_pair_t  sq_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    sq_nxt.a.hit   = up_geom.a.hit;
    sq_nxt.a.hold  = up_geom.a.hold;
    sq_nxt.a.level = up_geom.a.level;
    sq_nxt.a.sqx   = up_geom.a.dx * up_geom.a.dx;
    sq_nxt.a.sqy   = up_geom.a.dy * up_geom.a.dy;
    sq_nxt.b.hit   = up_geom.b.hit;
    sq_nxt.b.hold  = up_geom.b.hold;
    sq_nxt.b.level = up_geom.b.level;
    sq_nxt.b.sqx   = up_geom.b.dx * up_geom.b.dx;
    sq_nxt.b.sqy   = up_geom.b.dy * up_geom.b.dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sq_r <= sq_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_sq    = sq_r;

endmodule
`default_nettype wire

[hdl/tprc_decide.sv]
// Decision stage: sums squared distances and applies the ranking rules in order.
// Holds the result register. Depends on tprc_pkg.
`default_nettype none
module tprc_decide (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                low_res_first,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire tprc_pkg::sq_pair_t  up_sq,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output logic                     dn_after
);

  logic                         valid_r;
  logic                         after_r;
  logic                         after_nxt;
  logic                         lvl;
  logic [tprc_pkg::SQ_W-1:0]    da;
  logic [tprc_pkg::SQ_W-1:0]    db;

  assign up_ready = !valid_r || dn_ready;

  // Each squared gap is at most 2^62, so the sum fits without a carry out.
  assign da  = up_sq.a.sqx + up_sq.a.sqy;
  assign db  = up_sq.b.sqx + up_sq.b.sqy;
  assign lvl = tprc_pkg::level_after(up_sq.a.level, up_sq.b.level, low_res_first);

  always_comb begin
    if (up_sq.a.hit && up_sq.b.hit && (up_sq.a.level != up_sq.b.level)) begin
      after_nxt = lvl;
    end else if (up_sq.a.hit && !up_sq.b.hit) begin
      after_nxt = 1'b0;
    end else if (!up_sq.a.hit && up_sq.b.hit) begin
      after_nxt = 1'b1;
    end else if (up_sq.a.hold && up_sq.b.hold) begin
      after_nxt = lvl;
    end else if (up_sq.a.hold) begin
      after_nxt = 1'b0;
    end else if (up_sq.b.hold) begin
      after_nxt = 1'b1;
    end else if (da < db) begin
      after_nxt = 1'b0;
    end else if (da > db) begin
      after_nxt = 1'b1;
    end else begin
      after_nxt = lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      after_r <= after_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_after = after_r;

endmodule
`default_nettype wire

[hdl/tile_request_priority_compare_top.sv]
// Top level of the tile request priority compare block: config registers, input register,
// and the geometry, square and decision stages. Depends on tprc_pkg and the tprc_* modules.
`default_nettype none
// Compares two tile read requests and reports whether request A ranks after request B,
// using region overlap, focus containment, squared distance to the focus and level, in
// that order. One pair is accepted per cycle while in_stall is low; each accepted beat
// passes through the four register stages (input, geometry, gap squares, result).
// Any stage drains into the next while the result register waits, so a stall on the
// result side reaches in_stall only once every stage is full. Configuration registers
// act on beats already in flight and are meant to be written while nothing is in flight.
module tile_request_priority_compare_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [tprc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tprc_pkg::REG_W-1:0]         cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tprc_pkg::COORD_W-1:0]       in_first_x,
  input  wire logic [tprc_pkg::COORD_W-1:0]       in_first_y,
  input  wire logic [tprc_pkg::COORD_W-1:0]       in_first_w,
  input  wire logic [tprc_pkg::COORD_W-1:0]       in_first_h,
  input  wire logic [tprc_pkg::LEVEL_W-1:0]       in_first_level,
  input  wire logic [tprc_pkg::COORD_W-1:0]       in_second_x,
  input  wire logic [tprc_pkg::COORD_W-1:0]       in_second_y,
  input  wire logic [tprc_pkg::COORD_W-1:0]       in_second_w,
  input  wire logic [tprc_pkg::COORD_W-1:0]       in_second_h,
  input  wire logic [tprc_pkg::LEVEL_W-1:0]       in_second_level,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_first_ranks_after
);

  tprc_pkg::cfg_t        cfg_r;
  tprc_pkg::cfg_t        cfg_nxt;

  logic                  in_valid_r;
  tprc_pkg::req_pair_t   req_r;
  logic                  in_ready;

  logic                  geom_up_ready;
  logic                  geom_valid;
  tprc_pkg::geom_pair_t  geom;
  logic                  sq_up_ready;
  logic                  sq_valid;
  tprc_pkg::sq_pair_t    sq;
  logic                  dec_up_ready;

  // Configuration decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tprc_pkg::REG_FOCUS_X:       cfg_nxt.focus_x       = cfg_wdata[tprc_pkg::COORD_W-1:0];
        tprc_pkg::REG_FOCUS_Y:       cfg_nxt.focus_y       = cfg_wdata[tprc_pkg::COORD_W-1:0];
        tprc_pkg::REG_LOW_RES_FIRST: cfg_nxt.low_res_first = cfg_wdata[0];
        tprc_pkg::REG_REGION_COUNT:  cfg_nxt.region_count  = cfg_wdata[1:0];
        default: begin
          for (int i = 0; i < tprc_pkg::REGION_SLOTS; i++) begin
            if (cfg_index == tprc_pkg::REG_REGION_BASE + tprc_pkg::CFG_IDX_W'(2 * i)) begin
              cfg_nxt.region_origin[i] = cfg_wdata;
            end
            if (cfg_index == tprc_pkg::REG_REGION_BASE + tprc_pkg::CFG_IDX_W'(2 * i + 1))
            begin
              cfg_nxt.region_extent[i] = cfg_wdata;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input register
  assign in_ready = !in_valid_r || geom_up_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r.a.x     <= in_first_x;
      req_r.a.y     <= in_first_y;
      req_r.a.w     <= in_first_w;
      req_r.a.h     <= in_first_h;
      req_r.a.level <= in_first_level;
      req_r.b.x     <= in_second_x;
      req_r.b.y     <= in_second_y;
      req_r.b.w     <= in_second_w;
      req_r.b.h     <= in_second_h;
      req_r.b.level <= in_second_level;
    end
  end

  tprc_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid_r),
    .up_ready (geom_up_ready),
    .up_req   (req_r),
    .dn_valid (geom_valid),
    .dn_ready (sq_up_ready),
    .dn_geom  (geom)
  );

  tprc_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (geom_valid),
    .up_ready (sq_up_ready),
    .up_geom  (geom),
    .dn_valid (sq_valid),
    .dn_ready (dec_up_ready),
    .dn_sq    (sq)
  );

  tprc_decide u_decide (
    .clk           (clk),
    .rst_n         (rst_n),
    .low_res_first (cfg_r.low_res_first),
    .up_valid      (sq_valid),
    .up_ready      (dec_up_ready),
    .up_sq         (sq),
    .dn_valid      (out_valid),
    .dn_ready      (!out_stall),
    .dn_after      (out_first_ranks_after)
  );

endmodule
`default_nettype wire

[tb/sv/tprc_rank_checker.sv]
`timescale 1ns / 100ps
// Rank checker for the tile request priority compare block: mirrors the register writes,
// predicts the rank bit of every accepted request pair and compares result beats in order.
// Depends on tprc_pkg only.
module tprc_rank_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tprc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tprc_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  tprc_pkg::req_t                 first_req,
  input  tprc_pkg::req_t                 second_req,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_first_ranks_after,
  output int                             mismatch_count,
  output int                             ranks_in_flight,
  output int                             ranks_checked
);
  import tprc_pkg::*;

  logic [COORD_W-1:0] focus_col;
  logic [COORD_W-1:0] focus_row;
  logic               lower_level_first;
  logic [1:0]         slots_used;
  logic [REG_W-1:0]   slot_origin [REGION_SLOTS];
  logic [REG_W-1:0]   slot_extent [REGION_SLOTS];
  logic               pending_ranks [$];

  function automatic logic level_breaks_late(logic [LEVEL_W-1:0] la, logic [LEVEL_W-1:0] lb);
    if (la == lb) return 1'b0;
    return lower_level_first ? (la < lb) : (la > lb);
  endfunction

  // Region edges are inclusive on both sides; a count above the slot number uses all slots.
  function automatic logic touches_slot(longint x1, longint y1, longint x2, longint y2);
    longint left, top, right, bottom;
    int     active;
    logic   hit;
    active = (slots_used > REGION_SLOTS) ? REGION_SLOTS : int'(slots_used);
    hit    = 1'b0;
    for (int i = 0; i < active; i++) begin
      left   = {32'd0, slot_origin[i][63:32]};
      top    = {32'd0, slot_origin[i][31:0]};
      right  = left + {32'd0, slot_extent[i][63:32]};
      bottom = top + {32'd0, slot_extent[i][31:0]};
      if (!(left > x2 || top > y2 || right < x1 || bottom < y1)) hit = 1'b1;
    end
    return hit;
  endfunction

  // Low end wins when the span is inverted (zero size).
  function automatic longint unsigned gap_sq(longint lo, longint hi, longint f);
    longint nearest, d;
    if (f < lo) begin
      nearest = lo;
    end else if (f > hi) begin
      nearest = hi;
    end else begin
      nearest = f;
    end
    d = (nearest > f) ? nearest - f : f - nearest;
    return longint'(d * d);
  endfunction

  function automatic logic predict_ranks_after(req_t a, req_t b);
    longint          ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, fx, fy;
    logic            a_hit, b_hit, a_holds, b_holds;
    longint unsigned a_dist, b_dist;
    ax1 = {33'd0, a.x};
    ay1 = {33'd0, a.y};
    ax2 = ax1 + {33'd0, a.w} - 1;
    ay2 = ay1 + {33'd0, a.h} - 1;
    bx1 = {33'd0, b.x};
    by1 = {33'd0, b.y};
    bx2 = bx1 + {33'd0, b.w} - 1;
    by2 = by1 + {33'd0, b.h} - 1;
    fx  = {33'd0, focus_col};
    fy  = {33'd0, focus_row};
    a_hit = touches_slot(ax1, ay1, ax2, ay2);
    b_hit = touches_slot(bx1, by1, bx2, by2);
    if (a_hit && b_hit && a.level != b.level) return level_breaks_late(a.level, b.level);
    if (a_hit != b_hit) return b_hit;
    a_holds = fx >= ax1 && fy >= ay1 && fx <= ax2 && fy <= ay2;
    b_holds = fx >= bx1 && fy >= by1 && fx <= bx2 && fy <= by2;
    if (a_holds && b_holds) return level_breaks_late(a.level, b.level);
    if (a_holds != b_holds) return b_holds;
    a_dist = gap_sq(ax1, ax2, fx) + gap_sq(ay1, ay2, fy);
    b_dist = gap_sq(bx1, bx2, fx) + gap_sq(by1, by2, fy);
    if (a_dist != b_dist) return a_dist > b_dist;
    return level_breaks_late(a.level, b.level);
  endfunction

  task automatic flag_mismatch(string why, logic want_bit, logic got_bit);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] result beat %0d, %s: expected first_ranks_after=%b, got %b",
               $time, ranks_checked, why, want_bit, got_bit);
    end
  endtask

  always @(posedge clk) begin
    logic                 want_bit;
    logic [CFG_IDX_W-1:0] slot_offset;
    if (!rst_n) begin
      focus_col         = '0;
      focus_row         = '0;
      lower_level_first = 1'b0;
      slots_used        = '0;
      for (int i = 0; i < REGION_SLOTS; i++) begin
        slot_origin[i] = '0;
        slot_extent[i] = '0;
      end
      pending_ranks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FOCUS_X:       focus_col = cfg_wdata[COORD_W-1:0];
          REG_FOCUS_Y:       focus_row = cfg_wdata[COORD_W-1:0];
          REG_LOW_RES_FIRST: lower_level_first = cfg_wdata[0];
          REG_REGION_COUNT:  slots_used = cfg_wdata[1:0];
          default: begin
            // slots sit in origin/extent pairs from the region base upward
            slot_offset = cfg_index - REG_REGION_BASE;
            if (cfg_index >= REG_REGION_BASE && slot_offset[2:1] < REGION_SLOTS) begin
              if (slot_offset[0]) begin
                slot_extent[slot_offset[1]] = cfg_wdata;
              end else begin
                slot_origin[slot_offset[1]] = cfg_wdata;
              end
            end
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_ranks.size() == 0) begin
          flag_mismatch("beat with nothing outstanding", 1'bx, out_first_ranks_after);
        end else begin
          want_bit = pending_ranks.pop_front();
          ranks_checked++;
          if (want_bit !== out_first_ranks_after) begin
            flag_mismatch("wrong rank", want_bit, out_first_ranks_after);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_ranks = {pending_ranks, predict_ranks_after(first_req, second_req)};
      end
    end
    ranks_in_flight = pending_ranks.size();
  end

endmodule

[tb/sv/tile_request_priority_compare_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for tile_request_priority_compare_top: register setups, directed and random
// request pairs under several flow-control profiles. Checking lives in tprc_rank_checker.
module tile_request_priority_compare_top_tb;
  import tprc_pkg::*;

  localparam logic [COORD_W-1:0] COORD_MAX         = '1;
  localparam int                 RANDOM_SETUPS     = 8;
  localparam int                 PAIRS_PER_SETUP   = 75;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [REG_W-1:0]     cfg_wdata  = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  req_t                 first_req  = '0;
  req_t                 second_req = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic                 out_first_ranks_after;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int pairs_sent         = 0;
  int mismatch_count;
  int ranks_in_flight;
  int ranks_checked;

  // what the current setup wrote, used to aim requests at interesting places
  longint           aim_col;
  longint           aim_row;
  logic             aim_lrf;
  logic [1:0]       aim_slots;
  logic [REG_W-1:0] region_corner [REGION_SLOTS];
  logic [REG_W-1:0] region_span   [REGION_SLOTS];

  always #5 clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < receiver_stall_pct);

  tile_request_priority_compare_top i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_x            (first_req.x),
    .in_first_y            (first_req.y),
    .in_first_w            (first_req.w),
    .in_first_h            (first_req.h),
    .in_first_level        (first_req.level),
    .in_second_x           (second_req.x),
    .in_second_y           (second_req.y),
    .in_second_w           (second_req.w),
    .in_second_h           (second_req.h),
    .in_second_level       (second_req.level),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_first_ranks_after (out_first_ranks_after)
  );

  tprc_rank_checker i_rank_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .first_req             (first_req),
    .second_req            (second_req),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_first_ranks_after (out_first_ranks_after),
    .mismatch_count        (mismatch_count),
    .ranks_in_flight       (ranks_in_flight),
    .ranks_checked         (ranks_checked)
  );

  function automatic req_t mk(longint x, longint y, longint w, longint h, int lvl);
    req_t r;
    r.x     = x[COORD_W-1:0];
    r.y     = y[COORD_W-1:0];
    r.w     = w[COORD_W-1:0];
    r.h     = h[COORD_W-1:0];
    r.level = lvl[LEVEL_W-1:0];
    return r;
  endfunction

  function automatic longint jitter(longint c, int spread);
    longint v;
    v = c + longint'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  function automatic longint pick_coord(longint c);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return jitter(c, 80);
    if (sel < 85) return $urandom & 32'h7FFF_FFFF;
    if (sel < 92) return 0;
    return COORD_MAX;
  endfunction

  function automatic longint pick_size();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 6) return 0;
    if (sel < 76) return $urandom_range(1, 40);
    if (sel < 90) return $urandom & 32'h7FFF_FFFF;
    return COORD_MAX;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Unused upper bits carry junk so that the register widths get exercised.
  task automatic load_registers(logic [REG_W-1:0] junk);
    write_reg(REG_FOCUS_X, {junk[REG_W-1:COORD_W], aim_col[COORD_W-1:0]});
    write_reg(REG_FOCUS_Y, {junk[REG_W-1:COORD_W], aim_row[COORD_W-1:0]});
    write_reg(REG_LOW_RES_FIRST, {junk[REG_W-1:1], aim_lrf});
    write_reg(REG_REGION_COUNT, {junk[REG_W-1:2], aim_slots});
    for (int s = 0; s < REGION_SLOTS; s++) begin
      write_reg(REG_REGION_BASE + CFG_IDX_W'(2 * s), region_corner[s]);
      write_reg(REG_REGION_BASE + CFG_IDX_W'(2 * s + 1), region_span[s]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_pair(req_t a, req_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    first_req  <= a;
    second_req <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    pairs_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ranks_in_flight != 0) @(negedge clk);
  endtask

  task automatic pick_centre(output longint cx, output longint cy);
    int s;
    if ($urandom_range(1)) begin
      cx = aim_col;
      cy = aim_row;
    end else begin
      s  = $urandom_range(REGION_SLOTS - 1);
      cx = {32'd0, region_corner[s][63:32]};
      cy = {32'd0, region_corner[s][31:0]};
    end
  endtask

  task automatic random_pair();
    longint cx, cy;
    req_t   a, b;
    pick_centre(cx, cy);
    a = mk(pick_coord(cx), pick_coord(cy), pick_size(), pick_size(), $urandom_range(31));
    pick_centre(cx, cy);
    b = mk(pick_coord(cx), pick_coord(cy), pick_size(), pick_size(), $urandom_range(31));
    case ($urandom_range(9))
      0, 1: begin
        // same tile: only the level can separate them
        b       = a;
        b.level = LEVEL_W'($urandom);
      end
      2, 3: b.level = a.level;
      default: ;
    endcase
    send_pair(a, b);
  endtask

  task automatic choose_setup(int p);
    case (p)
      0: begin
        aim_col   = 0;
        aim_row   = 0;
        aim_lrf   = 1'b0;
        aim_slots = 2'd0;
        for (int s = 0; s < REGION_SLOTS; s++) begin
          region_corner[s] = '0;
          region_span[s]   = '0;
        end
      end
      1: begin
        aim_col          = 1000 + $urandom_range(4000);
        aim_row          = 1000 + $urandom_range(4000);
        aim_lrf          = 1'b1;
        aim_slots        = 2'd1;
        region_corner[0] = {32'(jitter(aim_col, 60)), 32'(jitter(aim_row, 60))};
        region_span[0]   = {32'($urandom_range(40)), 32'($urandom_range(40))};
        region_corner[1] = {$urandom, $urandom};
        region_span[1]   = {$urandom, $urandom};
      end
      2: begin
        aim_col          = COORD_MAX;
        aim_row          = COORD_MAX;
        aim_lrf          = 1'b0;
        aim_slots        = 2'd2;
        region_corner[0] = '1;
        region_span[0]   = '1;
        region_corner[1] = {32'(COORD_MAX - 50), 32'(COORD_MAX - 50)};
        region_span[1]   = {32'd20, 32'd20};
      end
      default: begin
        if (p == 3 || $urandom_range(1)) begin
          aim_col = $urandom & 32'h7FFF_FFFF;
          aim_row = $urandom & 32'h7FFF_FFFF;
        end else begin
          aim_col = $urandom_range(5000);
          aim_row = $urandom_range(5000);
        end
        aim_lrf   = (p == 3) ? 1'b1 : 1'($urandom);
        aim_slots = (p == 3) ? 2'd3 : 2'($urandom);
        for (int s = 0; s < REGION_SLOTS; s++) begin
          if ($urandom_range(3) == 0) begin
            region_corner[s] = {$urandom, $urandom};
            region_span[s]   = {$urandom, $urandom};
          end else begin
            region_corner[s] = {32'(jitter(aim_col, 100)), 32'(jitter(aim_row, 100))};
            region_span[s]   = {32'($urandom_range(100)), 32'($urandom_range(100))};
          end
        end
      end
    endcase
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: slot 0 covers 0..10 inclusive, slot 1 is the single pixel 200,200,
    // focus at 100,100, region count above the slot number.
    aim_col          = 100;
    aim_row          = 100;
    aim_lrf          = 1'b1;
    aim_slots        = 2'd3;
    region_corner[0] = '0;
    region_span[0]   = {32'd10, 32'd10};
    region_corner[1] = {32'd200, 32'd200};
    region_span[1]   = '0;
    load_registers('0);
    send_pair(mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 31));
    send_pair(mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 31),
              mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0));
    send_pair(mk(0, 0, COORD_MAX, COORD_MAX, 5), mk(COORD_MAX, COORD_MAX, 1, 1, 5));
    send_pair(mk(5, 5, 1, 1, 3), mk(500, 500, 4, 4, 3));
    send_pair(mk(500, 500, 4, 4, 3), mk(5, 5, 1, 1, 3));
    send_pair(mk(5, 5, 2, 2, 1), mk(8, 8, 2, 2, 9));
    send_pair(mk(8, 8, 2, 2, 9), mk(5, 5, 2, 2, 1));
    send_pair(mk(5, 5, 2, 2, 4), mk(195, 195, 10, 10, 4));
    // far edge of a region is inside it
    send_pair(mk(10, 10, 1, 1, 0), mk(11, 11, 1, 1, 0));
    send_pair(mk(11, 0, 0, 5, 2), mk(0, 11, 5, 0, 2));
    send_pair(mk(90, 90, 20, 20, 2), mk(300, 300, 5, 5, 2));
    send_pair(mk(300, 300, 5, 5, 2), mk(90, 90, 20, 20, 2));
    send_pair(mk(99, 99, 3, 3, 7), mk(100, 100, 1, 1, 2));
    send_pair(mk(100, 100, 1, 1, 6), mk(99, 99, 2, 2, 6));
    send_pair(mk(120, 100, 5, 5, 0), mk(100, 130, 5, 5, 0));
    send_pair(mk(110, 100, 1, 1, 3), mk(90, 100, 1, 1, 6));
    send_pair(mk(90, 100, 1, 1, 6), mk(110, 100, 1, 1, 3));
    // zero-size spans clamp the focus to the low end below the origin, else to origin-1
    send_pair(mk(100, 50, 0, 5, 1), mk(100, 150, 3, 0, 1));
    send_pair(mk(101, 101, 0, 0, 31), mk(100, 100, 0, 0, 0));
    send_pair(mk(COORD_MAX, 0, 1, COORD_MAX, 0), mk(0, COORD_MAX, COORD_MAX, 1, 31));
    send_pair(mk(COORD_MAX, COORD_MAX, 1, 1, 17), mk(COORD_MAX, COORD_MAX, 1, 1, 17));
    drain();

    for (int p = 0; p < RANDOM_SETUPS; p++) begin
      choose_setup(p);
      load_registers((p == 0) ? '0 : {$urandom, $urandom});
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
        default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
      repeat (PAIRS_PER_SETUP) random_pair();
      drain();
    end

    // let any stray beat show up before the verdict
    repeat (8) @(negedge clk);
    $display("Checked %0d rank results from %0d request pairs over %0d register setups,",
             ranks_checked, pairs_sent, RANDOM_SETUPS + 1);
    $display("with sender idle and receiver stall rates of 0, 19 and 83 percent; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && ranks_in_flight == 0) begin
      $display("** tile_request_priority_compare_top: PASSED **");
    end else begin
      $display("** tile_request_priority_compare_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d rank results outstanding.", ranks_in_flight);
    $display("** tile_request_priority_compare_top: FAILED **");
    $finish;
  end

endmodule

[files.f]
hdl/tprc_pkg.sv
hdl/tprc_geom.sv
hdl/tprc_square.sv
hdl/tprc_decide.sv
hdl/tile_request_priority_compare_top.sv
tb/sv/tprc_rank_checker.sv
tb/sv/tile_request_priority_compare_top_tb.sv
